### hdl/whcp_pkg.sv
// Package for the wheel halving character picker: codes, types and charset tables.
package whcp_pkg;

    // Number of characters in each charset
    localparam int SET_LEN   = 26;
    // Stored length of each table row
    localparam int TABLE_LEN = 26;
    localparam int NUM_SETS  = 7;

    // Button codes
    localparam logic [2:0] BTN_NONE    = 3'd0;
    localparam logic [2:0] BTN_PRESS   = 3'd1;
    localparam logic [2:0] BTN_PLAY    = 3'd2;
    localparam logic [2:0] BTN_REWIND  = 3'd3;
    localparam logic [2:0] BTN_FORWARD = 3'd4;
    localparam logic [2:0] BTN_LEFT    = 3'd5;
    localparam logic [2:0] BTN_RIGHT   = 3'd6;

    // Set indexes and window constants
    localparam logic [2:0] FIRST_SET   = 3'd0;
    localparam logic [2:0] CURSOR_SET  = 3'd6;
    localparam logic [2:0] NUMERIC_SET = 3'd6;
    localparam logic [3:0] START_HALF  = 4'd13;
    localparam logic [2:0] CENTRE_POS  = 3'd3;
    localparam logic [2:0] LAST_POS    = 3'd6;

    // Emitted control codes
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_SPACE     = 8'd32;
    localparam logic [7:0] CODE_CUR_LEFT  = 8'd28;
    localparam logic [7:0] CODE_CUR_RIGHT = 8'd29;

    typedef logic [TABLE_LEN*8-1:0] charset_t;

    // One result item
    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_code;
        logic [2:0] set_shown;
        logic [4:0] window_base;
        logic [3:0] window_len;
        logic [2:0] wheel_pos;
    } result_t;

    // Charsets, first character in the top byte
    localparam charset_t CHAR_TABLES [NUM_SETS] = '{
        charset_t'("abcdefghijklmnopqrstuvwxyz"),
        charset_t'("ABCDEFGHIJKLMNOPQRSTUVWXYZ"),
        charset_t'("0123456789.,/!@#$%^&*()[]?"),
        {8'h7E, 8'h60, 8'h2B, 8'h2D, 8'h3D, 8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h7C,
         8'h3A, 8'h3B, 8'h5C, 8'h27, 8'h22, 8'h5F, 8'hA3, 8'hA2, 8'hA5, 8'hB5,
         8'hF7, 8'hA9, 8'hAE, 8'hA1, 8'hBF, 8'hA7},
        {8'hE0, 8'hE1, 8'hE2, 8'hE4, 8'hE5, 8'hE3, 8'hE8, 8'hE9, 8'hEA, 8'hEB,
         8'hEC, 8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF6, 8'hF8, 8'hF5,
         8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hF1, 8'hFF},
        {8'hC0, 8'hC1, 8'hC2, 8'hC4, 8'hC5, 8'hC3, 8'hC8, 8'hC9, 8'hCA, 8'hCB,
         8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD2, 8'hD3, 8'hD4, 8'hD6, 8'hD8, 8'hD5,
         8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hD1, 8'hDF},
        charset_t'("0123456789.-E01234567+-*/^")
    };

    // Character lookup; out-of-range index or set gives 0
    function automatic logic [7:0] table_byte(input logic numeric_only,
                                              input logic [2:0] set_idx,
                                              input logic [5:0] idx);
        logic [2:0] t;
        charset_t   row;
        logic [7:0] res;
        t = numeric_only ? NUMERIC_SET : set_idx;
        res = 8'd0;
        if (t <= CURSOR_SET && 32'(idx) < TABLE_LEN && 32'(idx) < SET_LEN)
        begin
            row = CHAR_TABLES[t];
            res = row[(TABLE_LEN - 1 - int'(idx[4:0])) * 8 +: 8];
        end
        return res;
    endfunction

endpackage

### hdl/wheel_halving_char_picker_top.sv
// Top level of the wheel halving character picker.
// Results are registered: an accepted input loads the result register directly while it is free.
// Throughput: one item per cycle; the state update is a single pass of
// next-state logic. While a result waits, a skid register takes one more item,
// then input stalls until the result register frees.
// Reset: asynchronous, active low; set 0, window base 0, length 13, position 3.
module wheel_halving_char_picker_top
    import whcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_en,
    input  logic       cfg_write_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] button,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       char_valid,
    output logic [7:0] char_code,
    output logic [2:0] set_shown,
    output logic [4:0] window_base,
    output logic [3:0] window_len,
    output logic [2:0] wheel_pos
);

    logic       numeric_only_reg;
    logic [2:0] set_index_reg,  set_index_next;
    logic [4:0] base_index_reg, base_index_next;
    logic [3:0] half_len_reg,   half_len_next;
    logic [2:0] step_pos_reg,   step_pos_next;

    logic       out_valid_reg,  out_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    result_t    out_data_reg,   out_data_next;
    result_t    skid_data_reg,  skid_data_next;

    logic       in_fire;
    logic       out_fire;
    logic       cursor;
    logic       emit;
    logic [7:0] code;
    logic       pass_right;
    logic       pass_do;
    logic       odd;
    result_t    result;

    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;
    assign cursor   = set_index_reg >= CURSOR_SET;
    assign odd      = half_len_reg[0];

    // Event decode and next state
    always_comb
    begin
        set_index_next  = set_index_reg;
        base_index_next = base_index_reg;
        half_len_next   = half_len_reg;
        step_pos_next   = step_pos_reg;
        emit            = 1'b0;
        code            = 8'd0;
        pass_do         = 1'b0;
        pass_right      = 1'b0;
        case (button)
            BTN_PRESS:
            begin
                base_index_next = 5'd0;
                half_len_next   = START_HALF;
                step_pos_next   = CENTRE_POS;
                if (numeric_only_reg)
                    set_index_next = cursor ? FIRST_SET : CURSOR_SET;
                else if (cursor)
                    set_index_next = FIRST_SET;
                else
                    set_index_next = set_index_reg + 3'd1;
            end
            BTN_PLAY:
            begin
                emit = 1'b1;
                code = CODE_NEWLINE;
            end
            BTN_REWIND:
            begin
                emit = 1'b1;
                code = CODE_BACKSPACE;
            end
            BTN_FORWARD:
            begin
                emit            = 1'b1;
                code            = CODE_SPACE;
                base_index_next = 5'd0;
                half_len_next   = START_HALF;
                step_pos_next   = CENTRE_POS;
            end
            BTN_LEFT:
            begin
                if (cursor)
                begin
                    emit = 1'b1;
                    code = CODE_CUR_LEFT;
                end
                else if (step_pos_reg == 3'd0)
                    pass_do = 1'b1;
                else
                    step_pos_next = step_pos_reg - 3'd1;
            end
            BTN_RIGHT:
            begin
                if (cursor)
                begin
                    emit = 1'b1;
                    code = CODE_CUR_RIGHT;
                end
                else if (step_pos_reg >= LAST_POS)
                begin
                    pass_do    = 1'b1;
                    pass_right = 1'b1;
                end
                else
                    step_pos_next = step_pos_reg + 3'd1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        // Passing an end: halve the window or pick a character
        if (pass_do)
        begin
            step_pos_next = CENTRE_POS;
            if (half_len_reg > 4'd1)
            begin
                if (pass_right)
                    base_index_next = base_index_reg + {1'b0, half_len_reg[3:1], 1'b0};
                half_len_next = {1'b0, half_len_reg[3:1]} + {3'd0, odd};
            end
            else
            begin
                emit = 1'b1;
                code = table_byte(numeric_only_reg, set_index_reg,
                                  {1'b0, base_index_reg} + {5'd0, pass_right});
                base_index_next = 5'd0;
                half_len_next   = START_HALF;
            end
        end
    end

    // Result item from the state after the event
    always_comb
    begin
        result.char_valid  = emit;
        result.char_code   = emit ? code : 8'd0;
        result.set_shown   = set_index_next;
        result.window_base = base_index_next;
        result.window_len  = half_len_next;
        result.wheel_pos   = step_pos_next;
    end

    // Output register and skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = result;
                out_valid_next = in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_data_next  = result;
            skid_valid_next = 1'b1;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numeric_only_reg <= 1'b0;
            set_index_reg    <= FIRST_SET;
            base_index_reg   <= 5'd0;
            half_len_reg     <= START_HALF;
            step_pos_reg     <= CENTRE_POS;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                numeric_only_reg <= cfg_write_data;
            if (in_fire)
            begin
                set_index_reg  <= set_index_next;
                base_index_reg <= base_index_next;
                half_len_reg   <= half_len_next;
                step_pos_reg   <= step_pos_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_stall    = skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign char_valid  = out_data_reg.char_valid;
    assign char_code   = out_data_reg.char_code;
    assign set_shown   = out_data_reg.set_shown;
    assign window_base = out_data_reg.window_base;
    assign window_len  = out_data_reg.window_len;
    assign wheel_pos   = out_data_reg.wheel_pos;

endmodule
